>>> src/mvnb_pkg.sv
// Shared constants, types and saturation helpers for the vertex normal builder.
package mvnb_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  // Width wide enough to compare any corner, index or vertex count.
  localparam int IDX_W = 17;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_CORNER = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_RANGE      = 2'd3;

  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic [31:0]        Q_ONE     = 32'h0001_0000;

  typedef struct packed {
    logic               frac30;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } ureq_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } uvec_t;

  function automatic logic signed [15:0] sat15(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607) begin
      return 24'sh7f_ffff;
    end else if (v < -25'sd8388608) begin
      return 24'sh80_0000;
    end
    return v[23:0];
  endfunction

endpackage

>>> src/mvnb_unit.sv
// Vector normalizer: scale to a fixed window, bit-serial root, bit-serial divides.
module mvnb_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mvnb_pkg::ureq_t req,
  output logic          done,
  output mvnb_pkg::uvec_t res_vec
);
  import mvnb_pkg::*;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_NORM = 3'd1;
  localparam logic [2:0] U_SQ   = 3'd2;
  localparam logic [2:0] U_SQRT = 3'd3;
  localparam logic [2:0] U_DSET = 3'd4;
  localparam logic [2:0] U_DIV  = 3'd5;

  logic [2:0]  state;
  logic        f30;
  logic [63:0] w [3];
  logic [2:0]  neg;
  logic [63:0] m;
  logic [1:0]  j;
  logic [61:0] acc;
  logic [32:0] rem;
  logic [30:0] root;
  logic [4:0]  cnt;
  logic [60:0] drem;
  logic [61:0] dsub;
  logic [30:0] q;

  logic [63:0] a_x, a_y, a_z, m0;
  logic [29:0] wj;
  logic [59:0] sq;
  logic [34:0] remt, trial;
  logic        take, dtake;
  logic [30:0] qn;
  logic [60:0] dinit;
  logic [61:0] sinit;
  logic signed [31:0] outq;

  always_comb begin
    a_x = req.x[63] ? 64'(-req.x) : 64'(req.x);
    a_y = req.y[63] ? 64'(-req.y) : 64'(req.y);
    a_z = req.z[63] ? 64'(-req.z) : 64'(req.z);
    m0  = a_x;
    if (a_y > m0) begin
      m0 = a_y;
    end
    if (a_z > m0) begin
      m0 = a_z;
    end
    wj    = w[j][29:0];
    sq    = wj * wj;
    remt  = {rem, acc[61:60]};
    trial = {2'b00, root, 2'b01};
    take  = remt >= trial;
    dtake = {1'b0, drem} >= dsub;
    qn    = q | (31'(dtake) << cnt);
    dinit = (f30 ? {1'b0, wj, 30'b0} : {16'b0, wj, 15'b0}) + 61'(root >> 1);
    sinit = f30 ? {1'b0, root, 30'b0} : {16'b0, root, 15'b0};
    outq  = neg[j] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            f30  <= req.frac30;
            w[0] <= a_x;
            w[1] <= a_y;
            w[2] <= a_z;
            neg  <= {req.z[63], req.y[63], req.x[63]};
            m    <= m0;
            if (m0 == 64'd0) begin
              res_vec <= '0;
              done    <= 1'b1;
            end else begin
              state <= U_NORM;
            end
          end
        end
        U_NORM: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (|m[63:37]) begin
            m <= m >> 8;
            for (int i = 0; i < 3; i++) w[i] <= w[i] >> 8;
          end else if (|m[63:30]) begin
            m <= m >> 1;
            for (int i = 0; i < 3; i++) w[i] <= w[i] >> 1;
          end else if (m[63:21] == '0) begin
            m <= m << 8;
            for (int i = 0; i < 3; i++) w[i] <= w[i] << 8;
          end else if (m[63:29] == '0) begin
            m <= m << 1;
            for (int i = 0; i < 3; i++) w[i] <= w[i] << 1;
          end else begin
            state <= U_SQ;
            j     <= 2'd0;
            acc   <= '0;
          end
        end
        U_SQ: begin
          acc <= acc + 62'(sq);
          if (j == 2'd2) begin
            state <= U_SQRT;
            cnt   <= '0;
            rem   <= '0;
            root  <= '0;
          end else begin
            j <= j + 2'd1;
          end
        end
        U_SQRT: begin
          if (take) begin
            rem  <= 33'(remt - trial);
            root <= {root[29:0], 1'b1};
          end else begin
            rem  <= remt[32:0];
            root <= {root[29:0], 1'b0};
          end
          acc <= acc << 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            state <= U_DSET;
            j     <= 2'd0;
          end
        end
        U_DSET: begin
          drem  <= dinit;
          dsub  <= sinit;
          q     <= '0;
          cnt   <= f30 ? 5'd30 : 5'd15;
          state <= U_DIV;
        end
        U_DIV: begin
          if (dtake) begin
            drem <= drem - dsub[60:0];
          end
          dsub <= dsub >> 1;
          q    <= qn;
          if (cnt == 5'd0) begin
            case (j)
              2'd0:    res_vec.x <= outq;
              2'd1:    res_vec.y <= outq;
              default: res_vec.z <= outq;
            endcase
            if (j == 2'd2) begin
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              j     <= j + 2'd1;
              state <= U_DSET;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

>>> src/mvnb_div.sv
// Bit-serial rounded divider for read positions, round(n * 2^16 / d), saturated.
module mvnb_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [34:0] num,
  input  logic [32:0]        den,
  output logic               done,
  output logic signed [31:0] quot
);
  import mvnb_pkg::*;

  logic        running;
  logic        neg;
  logic [50:0] nsh;
  logic [32:0] rem;
  logic [32:0] dv;
  logic [50:0] qacc;
  logic [5:0]  cnt;

  logic [34:0] mag;
  logic [50:0] ninit;
  logic [33:0] remt;
  logic        take;
  logic [50:0] qn;

  always_comb begin
    mag   = num[34] ? 35'(-num) : 35'(num);
    ninit = {mag, 16'b0} + 51'(den >> 1);
    remt  = {rem, nsh[50]};
    take  = remt >= {1'b0, dv};
    qn    = {qacc[49:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        neg     <= num[34];
        nsh     <= ninit;
        dv      <= den;
        rem     <= '0;
        qacc    <= '0;
        cnt     <= '0;
      end else if (running) begin
        rem  <= take ? 33'(remt - {1'b0, dv}) : remt[32:0];
        nsh  <= nsh << 1;
        qacc <= qn;
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd50) begin
          running <= 1'b0;
          done    <= 1'b1;
          if (!neg) begin
            quot <= (|qn[50:31]) ? COORD_MAX : $signed({1'b0, qn[30:0]});
          end else if ((|qn[50:32]) || (qn[31] && (|qn[30:0]))) begin
            quot <= COORD_MIN;
          end else begin
            quot <= -$signed(qn[31:0]);
          end
        end
      end
    end
  end

endmodule

>>> src/mesh_vertex_normal_builder.sv
// Top level: vertex and normal-sum memories, command sequencer, arithmetic units.
//
//  channel   | signals                                   | dir | notes
//  ----------+-------------------------------------------+-----+---------------------------
//  command   | start, busy, op, coord_*, corner_*,       | in  | taken when start && !busy
//            | read_index                                |     |
//  result    | done, pos_*, norm_*, status               | out | one word per command,
//            |                                           |     | valid for the done cycle
//  config    | cfg_we, cfg_data (scale_on_load)          | in  | written on any cfg_we edge
//
// Add vertex, clear mesh and bad commands report done on the next clock.
// A triangle normalizes both edge vectors with the bit-serial square root
// and bit-serial divides of the normalizer, forms their cross product in
// multiply steps, normalizes the face normal and does a sum read-modify-write
// per corner. A read runs a position divide per axis and one normalization.
// Reset clears count, bounds and the config bit; no memory sweep is run,
// because a normal sum is zeroed when its vertex slot is filled.
// Results cannot be stalled; busy drops in the cycle the result word is out.
module mesh_vertex_normal_builder #(
  parameter int MAX_VERTICES = mvnb_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [12:0]        corner_a,
  input  logic [12:0]        corner_b,
  input  logic [12:0]        corner_c,
  input  logic [11:0]        read_index,
  input  logic               cfg_we,
  input  logic               cfg_data,
  output logic               done,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [1:0]         status
);
  import mvnb_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TB    = 4'd1;
  localparam logic [3:0] S_TC    = 4'd2;
  localparam logic [3:0] S_TD    = 4'd3;
  localparam logic [3:0] S_E1    = 4'd4;
  localparam logic [3:0] S_E2    = 4'd5;
  localparam logic [3:0] S_CROSS = 4'd6;
  localparam logic [3:0] S_FNST  = 4'd7;
  localparam logic [3:0] S_FN    = 4'd8;
  localparam logic [3:0] S_SUMRD = 4'd9;
  localparam logic [3:0] S_SUMWR = 4'd10;
  localparam logic [3:0] S_RDW   = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;
  localparam logic [3:0] S_RN    = 4'd13;

  logic [3:0]  state;
  logic        scale_on_load;
  logic [CW-1:0] count;
  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];

  // storage: vertices are never cleared; sums are zeroed on vertex add
  logic [95:0] vmem [MAX_VERTICES];
  logic [71:0] smem [MAX_VERTICES];
  logic          vwe, vre, swe, sre;
  logic [AW-1:0] vwaddr, vraddr, swaddr, sraddr;
  logic [95:0]   vwdata, vrdata;
  logic [71:0]   swdata, srdata;

  logic [AW-1:0] cad [3];
  logic [1:0]    ci;
  logic [95:0]   pa, pb, pc;
  uvec_t         u, v;
  logic [2:0]    k;
  logic signed [63:0] crx, cry, crz;
  logic signed [15:0] fn [3];
  logic [31:0]   ext;
  logic [1:0]    dsel;

  ureq_t ureq;
  logic  ustart, udone;
  uvec_t uvec;
  logic signed [34:0] dnum;
  logic [32:0]        dden;
  logic               dstart, ddone;
  logic signed [31:0] dq;

  logic signed [31:0] coord [3];
  logic [AW-1:0] ca [3];
  logic          bad, full, range_err;
  logic [IDX_W-1:0] cnt_w;
  logic [AW-1:0] idx_a;
  logic signed [63:0] e1 [3], e2 [3];
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [31:0] ext_c, ab;
  logic signed [34:0] nx, ny;
  logic signed [23:0] ns [3];

  mvnb_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .start   (ustart),
    .req     (ureq),
    .done    (udone),
    .res_vec (uvec)
  );

  mvnb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quot  (dq)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    coord[0] = coord_x;
    coord[1] = coord_y;
    coord[2] = coord_z;
    cnt_w    = IDX_W'(count);
    ca[0]    = AW'(IDX_W'(corner_a) - IDX_W'(1));
    ca[1]    = AW'(IDX_W'(corner_b) - IDX_W'(1));
    ca[2]    = AW'(IDX_W'(corner_c) - IDX_W'(1));
    idx_a    = AW'(IDX_W'(read_index));
    bad = (corner_a == '0) || (corner_b == '0) || (corner_c == '0) ||
          (IDX_W'(corner_a) > cnt_w) || (IDX_W'(corner_b) > cnt_w) ||
          (IDX_W'(corner_c) > cnt_w);
    full      = (count == CW'(MAX_VERTICES));
    range_err = (IDX_W'(read_index) >= cnt_w);

    for (int i = 0; i < 3; i++) begin
      e1[i] = 64'(signed'(pb[32*i +: 32])) - 64'(signed'(pa[32*i +: 32]));
      e2[i] = 64'(signed'(pc[32*i +: 32])) - 64'(signed'(pa[32*i +: 32]));
    end

    // cross product terms, one per step
    case (k)
      3'd0:    begin ma = u.y; mb = v.z; end
      3'd1:    begin ma = u.z; mb = v.y; end
      3'd2:    begin ma = u.z; mb = v.x; end
      3'd3:    begin ma = u.x; mb = v.z; end
      3'd4:    begin ma = u.x; mb = v.y; end
      default: begin ma = u.y; mb = v.x; end
    endcase
    prod = ma * mb;

    // largest absolute bound; zero, or scale_on_load off, counts as one
    ext_c = '0;
    for (int i = 0; i < 3; i++) begin
      ab = lo[i][31] ? 32'(-lo[i]) : 32'(lo[i]);
      if (ab > ext_c) begin
        ext_c = ab;
      end
      ab = hi[i][31] ? 32'(-hi[i]) : 32'(hi[i]);
      if (ab > ext_c) begin
        ext_c = ab;
      end
    end
    if (!scale_on_load || ext_c == '0) begin
      ext_c = Q_ONE;
    end

    nx = (35'(signed'(vrdata[31:0])) <<< 1) - 35'(lo[0]) - 35'(hi[0]);
    ny = (35'(signed'(vrdata[63:32])) <<< 1) - 35'(lo[1]) - 35'(hi[1]);

    for (int i = 0; i < 3; i++) begin
      ns[i] = sat24(25'(signed'(srdata[24*i +: 24])) + 25'(fn[i]));
    end
  end

  // memory port control
  always_comb begin
    vwe    = 1'b0;
    vwaddr = count[AW-1:0];
    vwdata = {coord_z, coord_y, coord_x};
    vre    = 1'b0;
    vraddr = ca[0];
    swe    = 1'b0;
    swaddr = count[AW-1:0];
    swdata = '0;
    sre    = 1'b0;
    sraddr = idx_a;
    case (state)
      S_IDLE: begin
        if (start && op == OP_ADD && !full) begin
          vwe = 1'b1;
          swe = 1'b1;
        end
        if (start && op == OP_TRI && !bad) begin
          vre = 1'b1;
        end
        if (start && op == OP_READ && !range_err) begin
          vre    = 1'b1;
          vraddr = idx_a;
          sre    = 1'b1;
        end
      end
      S_TB: begin
        vre    = 1'b1;
        vraddr = cad[1];
      end
      S_TC: begin
        vre    = 1'b1;
        vraddr = cad[2];
      end
      S_SUMRD: begin
        sre    = 1'b1;
        sraddr = cad[ci];
      end
      S_SUMWR: begin
        swe    = 1'b1;
        swaddr = cad[ci];
        swdata = {ns[2], ns[1], ns[0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwaddr] <= vwdata;
    end
    if (vre) begin
      vrdata <= vmem[vraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      smem[swaddr] <= swdata;
    end
    if (sre) begin
      srdata <= smem[sraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      count         <= '0;
      scale_on_load <= 1'b0;
      ustart        <= 1'b0;
      dstart        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo[i] <= COORD_MAX;
        hi[i] <= COORD_MIN;
      end
    end else begin
      done   <= 1'b0;
      ustart <= 1'b0;
      dstart <= 1'b0;
      if (cfg_we) begin
        scale_on_load <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            pos_x  <= '0;
            pos_y  <= '0;
            pos_z  <= '0;
            norm_x <= '0;
            norm_y <= '0;
            norm_z <= '0;
            status <= ST_OK;
            case (op)
              OP_ADD: begin
                done <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                  for (int i = 0; i < 3; i++) begin
                    if (coord[i] < lo[i]) lo[i] <= coord[i];
                    if (coord[i] > hi[i]) hi[i] <= coord[i];
                  end
                end
              end
              OP_CLEAR: begin
                done  <= 1'b1;
                count <= '0;
                for (int i = 0; i < 3; i++) begin
                  lo[i] <= COORD_MAX;
                  hi[i] <= COORD_MIN;
                end
              end
              OP_TRI: begin
                if (bad) begin
                  done   <= 1'b1;
                  status <= ST_BAD_CORNER;
                end else begin
                  cad[0] <= ca[0];
                  cad[1] <= ca[1];
                  cad[2] <= ca[2];
                  state  <= S_TB;
                end
              end
              default: begin
                if (range_err) begin
                  done   <= 1'b1;
                  status <= ST_RANGE;
                end else begin
                  state <= S_RDW;
                end
              end
            endcase
          end
        end
        S_TB: begin
          pa    <= vrdata;
          state <= S_TC;
        end
        S_TC: begin
          pb    <= vrdata;
          state <= S_TD;
        end
        S_TD: begin
          pc          <= vrdata;
          ureq.frac30 <= 1'b1;
          ureq.x      <= e1[0];
          ureq.y      <= e1[1];
          ureq.z      <= e1[2];
          ustart      <= 1'b1;
          state       <= S_E1;
        end
        S_E1: begin
          if (udone) begin
            u           <= uvec;
            ureq.frac30 <= 1'b1;
            ureq.x      <= e2[0];
            ureq.y      <= e2[1];
            ureq.z      <= e2[2];
            ustart      <= 1'b1;
            state       <= S_E2;
          end
        end
        S_E2: begin
          if (udone) begin
            v     <= uvec;
            k     <= '0;
            crx   <= '0;
            cry   <= '0;
            crz   <= '0;
            state <= S_CROSS;
          end
        end
        S_CROSS: begin
          case (k)
            3'd0:    crx <= crx + prod;
            3'd1:    crx <= crx - prod;
            3'd2:    cry <= cry + prod;
            3'd3:    cry <= cry - prod;
            3'd4:    crz <= crz + prod;
            default: crz <= crz - prod;
          endcase
          k <= k + 3'd1;
          if (k == 3'd5) begin
            state <= S_FNST;
          end
        end
        S_FNST: begin
          ureq.frac30 <= 1'b0;
          ureq.x      <= crx;
          ureq.y      <= cry;
          ureq.z      <= crz;
          ustart      <= 1'b1;
          state       <= S_FN;
        end
        S_FN: begin
          if (udone) begin
            fn[0] <= sat15(uvec.x);
            fn[1] <= sat15(uvec.y);
            fn[2] <= sat15(uvec.z);
            ci    <= '0;
            state <= S_SUMRD;
          end
        end
        S_SUMRD: state <= S_SUMWR;
        S_SUMWR: begin
          // next corner is read only after this write lands
          if (ci == 2'd2) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            ci    <= ci + 2'd1;
            state <= S_SUMRD;
          end
        end
        S_RDW: begin
          ext    <= ext_c;
          dnum   <= nx;
          dden   <= {ext_c, 1'b0};
          dstart <= 1'b1;
          dsel   <= 2'd0;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (ddone) begin
            case (dsel)
              2'd0: begin
                pos_x  <= dq;
                dnum   <= ny;
                dden   <= {ext, 1'b0};
                dstart <= 1'b1;
                dsel   <= 2'd1;
              end
              2'd1: begin
                pos_y  <= dq;
                dnum   <= 35'(signed'(vrdata[95:64]));
                dden   <= {1'b0, ext};
                dstart <= 1'b1;
                dsel   <= 2'd2;
              end
              default: begin
                pos_z       <= dq;
                ureq.frac30 <= 1'b0;
                ureq.x      <= 64'(signed'(srdata[23:0]));
                ureq.y      <= 64'(signed'(srdata[47:24]));
                ureq.z      <= 64'(signed'(srdata[71:48]));
                ustart      <= 1'b1;
                state       <= S_RN;
              end
            endcase
          end
        end
        S_RN: begin
          if (udone) begin
            norm_x <= sat15(uvec.x);
            norm_y <= sat15(uvec.y);
            norm_z <= sat15(uvec.z);
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result word never overlaps a command in flight
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted command either finishes next cycle or holds busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted command lost");

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  // error words carry an all-zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> pos_x == '0 && pos_y == '0 && pos_z == '0 &&
    norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("error result with nonzero payload");

endmodule
